/* hw/rtl/segment_circle_hit_test_assert.svh */
// assertion macros for the segment circle hit test block
// used by the queue and back end files; expects clk and rst_n in scope
`ifndef SEGMENT_CIRCLE_HIT_TEST_ASSERT_SVH
`define SEGMENT_CIRCLE_HIT_TEST_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SHCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SHCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SHCT_ASSERT(label, prop, msg)
`define SHCT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hw/rtl/shct_pkg.sv */
// shared types and constants of the segment circle hit test block
// no dependencies
`default_nettype none
package shct_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int LIMB_W     = 32;
  localparam int SQ_IN_W    = 3 * LIMB_W;
  localparam int SQ_OUT_W   = 2 * SQ_IN_W;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int PIPE_DEPTH = 8;
  localparam int SQ_LAT     = 3;
  localparam logic [63:0] ONE2 = 64'(1) << (2 * FRAC_BITS);

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_LINE,
    MODE_VERT,
    MODE_POINT
  } mode_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  typedef struct packed {
    mode_t  mode;
    coord_t slope;
    diff_t  offs;    // line intercept minus center y
    coord_t cx;
    coord_t radius;
    coord_t x_lo;
    coord_t x_hi;
    diff_t  dx;      // x start minus center x
    diff_t  y_lo;    // lower y end minus center y
    diff_t  y_hi;    // center y minus upper y end
    diff_t  dy;      // center y minus y start
  } item_t;
endpackage
`default_nettype wire

/* hw/rtl/shct_if.sv */
// valid/ready channel interfaces of the segment circle hit test block
// no dependencies
`default_nettype none
interface shct_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] seg_x_start;
  logic signed [31:0] seg_y_start;
  logic signed [31:0] seg_x_end;
  logic signed [31:0] seg_y_end;
  logic signed [31:0] line_slope;
  logic signed [31:0] line_offset;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] circle_radius;
  logic               circle_alive;

  modport source (output valid, seg_x_start, seg_y_start, seg_x_end, seg_y_end, line_slope,
                  line_offset, center_x, center_y, circle_radius, circle_alive,
                  input ready);
  modport sink (input valid, seg_x_start, seg_y_start, seg_x_end, seg_y_end, line_slope,
                line_offset, center_x, center_y, circle_radius, circle_alive,
                output ready);
endinterface

interface shct_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

/* hw/rtl/shct_front.sv */
// front end: takes input transactions, sorts them into cases, forms differences
// depends on shct_pkg and shct_if
`default_nettype none
module shct_front import shct_pkg::*; (
  shct_in_if.sink in_ch,
  input  logic    q_full,
  output logic    push,
  output item_t   item
);
  coord_t x1, y1, x2, y2, cx, cy;

  assign x1 = in_ch.seg_x_start;
  assign y1 = in_ch.seg_y_start;
  assign x2 = in_ch.seg_x_end;
  assign y2 = in_ch.seg_y_end;
  assign cx = in_ch.center_x;
  assign cy = in_ch.center_y;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    if (!in_ch.circle_alive || in_ch.circle_radius[COORD_W-1]) begin
      item.mode = MODE_NONE;
    end else if (x1 != x2) begin
      item.mode = MODE_LINE;
    end else if (y1 == y2) begin
      item.mode = MODE_POINT;
    end else begin
      item.mode = MODE_VERT;
    end
    item.slope  = in_ch.line_slope;
    item.offs   = DIFF_W'(in_ch.line_offset) - DIFF_W'(cy);
    item.cx     = cx;
    item.radius = in_ch.circle_radius;
    item.x_lo   = (x1 < x2) ? x1 : x2;
    item.x_hi   = (x1 < x2) ? x2 : x1;
    item.dx     = DIFF_W'(x1) - DIFF_W'(cx);
    item.y_lo   = DIFF_W'((y1 < y2) ? y1 : y2) - DIFF_W'(cy);
    item.y_hi   = DIFF_W'(cy) - DIFF_W'((y1 < y2) ? y2 : y1);
    item.dy     = DIFF_W'(cy) - DIFF_W'(y1);
  end
endmodule
`default_nettype wire

/* hw/rtl/shct_queue.sv */
// short queue between the front end and the back end
// depends on shct_pkg and the assertion macro header
`default_nettype none
`include "segment_circle_hit_test_assert.svh"
module shct_queue import shct_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t head,
  output logic  q_valid,
  output logic  q_full
);
  item_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign head    = mem_r[rd_ptr_r];
  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      if (pop) rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

  `SHCT_ASSERT(a_cnt_bound, count_r <= QCNT_W'(QDEPTH), "queue count above depth")
  `SHCT_ASSERT_NEXT(a_cnt_up, push && !pop, count_r == $past(count_r) + 1'b1, "count missed a push")
  `SHCT_ASSERT_NEXT(a_ptr_gap, pop && !push, rd_ptr_r == QPTR_W'($past(rd_ptr_r) + 1'b1), "read pointer slip")
endmodule
`default_nettype wire

/* hw/rtl/shct_square.sv */
// pipelined square of a 96-bit signed value from 32-bit limb products
// depends on shct_pkg; three register stages, all held by en
`default_nettype none
module shct_square import shct_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [SQ_IN_W-1:0]  val,
  output logic [SQ_OUT_W-1:0]        sq
);
  logic [2*LIMB_W-1:0]            pp00_r, pp01_r, pp11_r;
  logic signed [2*LIMB_W+1:0]     pp02_r, pp12_r;
  logic signed [2*LIMB_W-1:0]     pp22_r;
  logic [4*LIMB_W+1:0]            sa_r;
  logic signed [SQ_OUT_W-1:0]     sb_r;
  logic [SQ_OUT_W-1:0]            sq_r;
  logic [LIMB_W-1:0]              l0, l1;
  logic signed [LIMB_W-1:0]       l2;

  assign l0 = val[LIMB_W-1:0];
  assign l1 = val[2*LIMB_W-1:LIMB_W];
  assign l2 = $signed(val[3*LIMB_W-1:2*LIMB_W]);
  assign sq = sq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= (2*LIMB_W)'(l0) * (2*LIMB_W)'(l0);
      pp01_r <= (2*LIMB_W)'(l0) * (2*LIMB_W)'(l1);
      pp11_r <= (2*LIMB_W)'(l1) * (2*LIMB_W)'(l1);
      pp02_r <= (2*LIMB_W+2)'($signed({1'b0, l0})) * (2*LIMB_W+2)'(l2);
      pp12_r <= (2*LIMB_W+2)'($signed({1'b0, l1})) * (2*LIMB_W+2)'(l2);
      pp22_r <= (2*LIMB_W)'(l2) * (2*LIMB_W)'(l2);
      // cross terms carry the factor of two in their shift
      sa_r <= (4*LIMB_W+2)'(pp00_r) + ((4*LIMB_W+2)'(pp01_r) << (LIMB_W + 1))
            + ((4*LIMB_W+2)'(pp11_r) << (2*LIMB_W));
      sb_r <= (SQ_OUT_W'(pp02_r) <<< (2*LIMB_W + 1)) + (SQ_OUT_W'(pp12_r) <<< (3*LIMB_W + 1))
            + (SQ_OUT_W'(pp22_r) <<< (4*LIMB_W));
      sq_r <= $unsigned($signed(SQ_OUT_W'(sa_r)) + sb_r);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/shct_back.sv */
// back end: exact fixed point hit evaluation pipeline and output register
// depends on shct_pkg, shct_if, shct_square and the assertion macro header
`default_nettype none
`include "segment_circle_hit_test_assert.svh"
module shct_back import shct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  item_t     head,
  input  logic      q_valid,
  output logic      pop,
  shct_out_if.source out_ch
);
  typedef struct packed {
    mode_t        mode;
    logic         dneg;
    logic [125:0] disc;
    logic         ppass;
    logic         qpass;
    logic         hv;
    logic         pt;
  } tail_t;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  out_valid_r, out_hit_r;
  mode_t                 out_mode_r;
  logic                  hit_nxt;

  // stage 1
  mode_t               mode1_r;
  logic signed [63:0]  cc1_r, ac1_r, rr1_r;
  logic signed [64:0]  ce1_r;
  logic signed [65:0]  dx2_1_r, ylo2_1_r, yhi2_1_r, dy2_1_r;
  diff_t               e1_r;
  coord_t              a1_r, xlo1_r, xhi1_r;
  logic [1:0]          yneg1_r;
  // stage 2
  mode_t               mode2_r;
  logic [63:0]         k2_r, r2_2_r;
  logic signed [63:0]  t2_r;
  logic signed [95:0]  pc2_r;
  logic signed [67:0]  vd2_r;
  logic signed [65:0]  ylo2_2_r, yhi2_2_r;
  logic [1:0]          yneg2_r;
  logic                pt2_r;
  coord_t              xlo2_r, xhi2_r;
  // stage 3
  mode_t               mode3_r;
  logic [63:0]         rk_ll3_r, rk_lh3_r, rk_hl3_r, rk_hh3_r, tt_ll3_r;
  logic signed [63:0]  tt_hh3_r;
  logic signed [65:0]  tt_hl3_r, lo_kh3_r, lo_kl3_r, hi_kh3_r, hi_kl3_r;
  logic signed [95:0]  pc3_r;
  logic                hv3_r, pt3_r;
  // stage 4
  mode_t               mode4_r;
  logic [127:0]        rk4_r;
  logic signed [129:0] tt4_r;
  logic signed [97:0]  lok4_r, hik4_r;
  logic signed [95:0]  pc4_r;
  logic                hv4_r, pt4_r;
  // stage 5
  mode_t               mode5_r;
  logic signed [129:0] disc5_r;
  logic signed [95:0]  p5_r, q5_r;
  logic                hv5_r, pt5_r;
  // stages 6 to 8 run beside the squaring units
  tail_t               tail_r [SQ_LAT];
  logic [SQ_OUT_W-1:0] psq, qsq, lhs;
  logic                okp, okq;

  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && q_valid;

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], q_valid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products of the raw inputs
      mode1_r  <= head.mode;
      cc1_r    <= 64'($signed(head.slope)) * 64'($signed(head.slope));
      ac1_r    <= 64'($signed(head.cx)) * 64'($signed(head.slope));
      rr1_r    <= 64'($signed(head.radius)) * 64'($signed(head.radius));
      ce1_r    <= 65'($signed(head.slope)) * 65'($signed(head.offs));
      dx2_1_r  <= 66'($signed(head.dx)) * 66'($signed(head.dx));
      ylo2_1_r <= 66'($signed(head.y_lo)) * 66'($signed(head.y_lo));
      yhi2_1_r <= 66'($signed(head.y_hi)) * 66'($signed(head.y_hi));
      dy2_1_r  <= 66'($signed(head.dy)) * 66'($signed(head.dy));
      e1_r     <= head.offs;
      a1_r     <= head.cx;
      xlo1_r   <= head.x_lo;
      xhi1_r   <= head.x_hi;
      yneg1_r  <= {head.y_hi[DIFF_W-1], head.y_lo[DIFF_W-1]};

      // k = one^2 + c^2, t = e*one + a*c, constant part of p
      mode2_r  <= mode1_r;
      k2_r     <= ONE2 + $unsigned(cc1_r);
      t2_r     <= (64'(e1_r) <<< FRAC_BITS) + ac1_r;
      r2_2_r   <= $unsigned(rr1_r);
      pc2_r    <= (96'(ce1_r) <<< FRAC_BITS) - (96'(a1_r) <<< (2 * FRAC_BITS));
      vd2_r    <= 68'(rr1_r) - 68'(dx2_1_r);
      ylo2_2_r <= ylo2_1_r;
      yhi2_2_r <= yhi2_1_r;
      yneg2_r  <= yneg1_r;
      pt2_r    <= (68'(rr1_r) >= (68'(dx2_1_r) + 68'(dy2_1_r)));
      xlo2_r   <= xlo1_r;
      xhi2_r   <= xhi1_r;

      // limb products of r2*k, t*t, lo*k and hi*k
      mode3_r  <= mode2_r;
      rk_ll3_r <= 64'(r2_2_r[31:0]) * 64'(k2_r[31:0]);
      rk_lh3_r <= 64'(r2_2_r[31:0]) * 64'(k2_r[63:32]);
      rk_hl3_r <= 64'(r2_2_r[63:32]) * 64'(k2_r[31:0]);
      rk_hh3_r <= 64'(r2_2_r[63:32]) * 64'(k2_r[63:32]);
      tt_hh3_r <= 64'($signed(t2_r[63:32])) * 64'($signed(t2_r[63:32]));
      tt_hl3_r <= 66'($signed(t2_r[63:32])) * 66'($signed({1'b0, t2_r[31:0]}));
      tt_ll3_r <= 64'(t2_r[31:0]) * 64'(t2_r[31:0]);
      lo_kh3_r <= 66'(xlo2_r) * 66'($signed({1'b0, k2_r[63:32]}));
      lo_kl3_r <= 66'(xlo2_r) * 66'($signed({1'b0, k2_r[31:0]}));
      hi_kh3_r <= 66'(xhi2_r) * 66'($signed({1'b0, k2_r[63:32]}));
      hi_kl3_r <= 66'(xhi2_r) * 66'($signed({1'b0, k2_r[31:0]}));
      pc3_r    <= pc2_r;
      // vertical chord against the open y span
      hv3_r    <= !vd2_r[67] && (yneg2_r[0] || (vd2_r > 68'(ylo2_2_r)))
                  && (yneg2_r[1] || (vd2_r > 68'(yhi2_2_r)));
      pt3_r    <= pt2_r;

      // sum the limb products
      mode4_r  <= mode3_r;
      rk4_r    <= 128'(rk_ll3_r) + (128'(rk_lh3_r) << 32) + (128'(rk_hl3_r) << 32)
                  + (128'(rk_hh3_r) << 64);
      tt4_r    <= 130'($signed({1'b0, tt_ll3_r})) + (130'(tt_hl3_r) <<< 33)
                  + (130'(tt_hh3_r) <<< 64);
      lok4_r   <= (98'(lo_kh3_r) <<< 32) + 98'(lo_kl3_r);
      hik4_r   <= (98'(hi_kh3_r) <<< 32) + 98'(hi_kl3_r);
      pc4_r    <= pc3_r;
      hv4_r    <= hv3_r;
      pt4_r    <= pt3_r;

      // discriminant and the two end distances along x
      mode5_r  <= mode4_r;
      disc5_r  <= $signed({2'b00, rk4_r}) - tt4_r;
      p5_r     <= 96'(lok4_r + 98'(pc4_r));
      q5_r     <= 96'(-98'(pc4_r) - hik4_r);
      hv5_r    <= hv4_r;
      pt5_r    <= pt4_r;

      tail_r[0].mode  <= mode5_r;
      tail_r[0].dneg  <= disc5_r[129];
      tail_r[0].disc  <= disc5_r[125:0];
      tail_r[0].ppass <= p5_r[95] || (p5_r == '0);
      tail_r[0].qpass <= q5_r[95] || (q5_r == '0);
      tail_r[0].hv    <= hv5_r;
      tail_r[0].pt    <= pt5_r;
      for (int i = 1; i < SQ_LAT; i++) tail_r[i] <= tail_r[i-1];

      out_hit_r  <= hit_nxt;
      out_mode_r <= tail_r[SQ_LAT-1].mode;
    end
  end

  shct_square u_sq_p (.clk(clk), .en(en), .val(p5_r), .sq(psq));
  shct_square u_sq_q (.clk(clk), .en(en), .val(q5_r), .sq(qsq));

  assign lhs = SQ_OUT_W'(tail_r[SQ_LAT-1].disc) << (2 * FRAC_BITS);
  assign okp = tail_r[SQ_LAT-1].ppass || (lhs >= psq);
  assign okq = tail_r[SQ_LAT-1].qpass || (lhs >= qsq);

  always_comb begin
    unique case (tail_r[SQ_LAT-1].mode)
      MODE_LINE:  hit_nxt = !tail_r[SQ_LAT-1].dneg && okp && okq;
      MODE_VERT:  hit_nxt = tail_r[SQ_LAT-1].hv;
      MODE_POINT: hit_nxt = tail_r[SQ_LAT-1].pt;
      default:    hit_nxt = 1'b0;
    endcase
  end

  `SHCT_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_r) && $stable(out_valid_r), "pipeline moved while stalled")
  `SHCT_ASSERT(a_none_no_hit, !(out_valid_r && out_mode_r == MODE_NONE && out_hit_r), "hit on a dead or negative circle")
  `SHCT_ASSERT_NEXT(a_pop_enters, pop, vld_r[0], "popped item did not enter the pipeline")
endmodule
`default_nettype wire

/* hw/rtl/segment_circle_hit_test.sv */
// top level of the segment circle hit test block
// depends on shct_pkg, shct_if, shct_front, shct_queue, shct_back
//
//   channel   dir   handshake        payload
//   in_ch     in    valid / ready    segment ends, slope, intercept, circle
//   out_ch    out   valid / ready    hit
//
// one transaction per cycle sustained while out_ch is ready; each result passes the queue,
// five arithmetic stages, three squaring stages and the output register, also when the queue
// is empty; the limb multipliers and the 192-bit squared compare set the stage count
// rst_n is synchronous and clears queue pointers, the queue count and pipeline valid bits only
// a stalled out_ch freezes the back end; the 4-entry queue takes up to four more transactions
`default_nettype none
module segment_circle_hit_test import shct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  shct_in_if.sink    in_ch,
  shct_out_if.source out_ch
);
  item_t front_item, q_head;
  logic  push, pop, q_valid, q_full;

  shct_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .item   (front_item)
  );

  shct_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .head    (q_head),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  shct_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_valid (q_valid),
    .pop     (pop),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire
